// File: hdl/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the rounded frame distance unit: fixed point
// format, register codes, geometry bundle and square root cell payload.
// ----------------------------------------------------------------------------
package rfd_pkg;

	// fixed point format, one pixel is ONE_UNIT
	localparam int FRAC_BITS = 4;
	localparam logic [15:0] ONE_UNIT = 16'(1 << FRAC_BITS);
	localparam logic [15:0] TWO_UNITS = 16'(2 << FRAC_BITS);

	// field widths
	localparam int COORD_W = 16;
	localparam int DIST_W = 18;
	localparam int DATA_W = 16;
	localparam int INDEX_W = 3;

	// square root chain: radicand, root and carried side term
	localparam int SQ_IN_W = 38;
	localparam int SQ_ROOT_W = 19;
	localparam int SIDE_W = 19;

	// register reset values
	localparam logic [15:0] RST_WIDTH = 16'd30720;
	localparam logic [15:0] RST_HEIGHT = 16'd17280;
	localparam logic [13:0] RST_THICK = 14'd128;
	localparam logic [14:0] RST_INSET = 15'h7fff;
	localparam logic [13:0] RST_RADIUS = 14'd256;

	// register indexes
	typedef enum logic [INDEX_W-1:0] {
		REG_OUTPUT_WIDTH    = 3'd0,
		REG_OUTPUT_HEIGHT   = 3'd1,
		REG_FRAME_THICKNESS = 3'd2,
		REG_INSET_LEFT      = 3'd3,
		REG_INSET_TOP       = 3'd4,
		REG_INSET_RIGHT     = 3'd5,
		REG_INSET_BOTTOM    = 3'd6,
		REG_CORNER_RADIUS   = 3'd7
	} cfg_reg_t;

	// resolved aperture geometry, rs2 in half units
	typedef struct packed {
		logic [13:0] l;
		logic [13:0] t;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] rs2;
	} geo_t;

	// payload handed from cell to cell
	typedef struct packed {
		logic [SQ_IN_W-1:0]          rem;
		logic [SQ_ROOT_W-1:0]        root;
		logic signed [SIDE_W-1:0]    m2;
	} sqrt_t;

endpackage

// File: hdl/rfd_geometry.sv
// ----------------------------------------------------------------------------
// rfd_geometry
// Configuration registers and the derived aperture geometry: resolved insets,
// inner size with one pixel minimum, and the clamped corner radius.
// ----------------------------------------------------------------------------
module rfd_geometry (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rfd_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [rfd_pkg::DATA_W-1:0]   cfg_data,
	output rfd_pkg::geo_t                geo
);
	import rfd_pkg::*;

	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [13:0] thick_q;
	logic [14:0] inset_l_q;
	logic [14:0] inset_t_q;
	logic [14:0] inset_r_q;
	logic [14:0] inset_b_q;
	logic [13:0] radius_q;

	logic [13:0] l_res, t_res, r_res, b_res;
	logic signed [17:0] w_raw, h_raw;
	logic [13:0] l_q, t_q;
	logic [15:0] w_q, h_q;
	logic [15:0] mn, hi2, r2, lo, rs2_n;
	logic [15:0] rs2_q;

	function automatic logic [13:0] resolve(input logic [14:0] raw, input logic [13:0] thick);
		return raw[14] ? thick : raw[13:0];
	endfunction

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			thick_q <= RST_THICK;
			inset_l_q <= RST_INSET;
			inset_t_q <= RST_INSET;
			inset_r_q <= RST_INSET;
			inset_b_q <= RST_INSET;
			radius_q <= RST_RADIUS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OUTPUT_WIDTH: width_q <= cfg_data;
				REG_OUTPUT_HEIGHT: height_q <= cfg_data;
				REG_FRAME_THICKNESS: thick_q <= cfg_data[13:0];
				REG_INSET_LEFT: inset_l_q <= cfg_data[14:0];
				REG_INSET_TOP: inset_t_q <= cfg_data[14:0];
				REG_INSET_RIGHT: inset_r_q <= cfg_data[14:0];
				REG_INSET_BOTTOM: inset_b_q <= cfg_data[14:0];
				REG_CORNER_RADIUS: radius_q <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// first level: insets and inner size
	always_comb begin
		l_res = resolve(inset_l_q, thick_q);
		t_res = resolve(inset_t_q, thick_q);
		r_res = resolve(inset_r_q, thick_q);
		b_res = resolve(inset_b_q, thick_q);
		w_raw = $signed({2'b00, width_q}) - $signed({4'b0000, l_res})
			- $signed({4'b0000, r_res});
		h_raw = $signed({2'b00, height_q}) - $signed({4'b0000, t_res})
			- $signed({4'b0000, b_res});
	end

	always_ff @(posedge clk) begin
		l_q <= l_res;
		t_q <= t_res;
		w_q <= (w_raw < $signed({2'b00, ONE_UNIT})) ? ONE_UNIT : w_raw[15:0];
		h_q <= (h_raw < $signed({2'b00, ONE_UNIT})) ? ONE_UNIT : h_raw[15:0];
	end

	// second level: radius in half units, clamped to one pixel and half the short side
	always_comb begin
		mn = (w_q < h_q) ? w_q : h_q;
		hi2 = (mn < TWO_UNITS) ? TWO_UNITS : mn;
		r2 = {1'b0, radius_q, 1'b0};
		lo = (r2 < TWO_UNITS) ? TWO_UNITS : r2;
		rs2_n = (lo > hi2) ? hi2 : lo;
	end

	always_ff @(posedge clk) begin
		rs2_q <= rs2_n;
	end

	assign geo = '{l: l_q, t: t_q, w: w_q, h: h_q, rs2: rs2_q};

endmodule

// File: hdl/rfd_front.sv
// ----------------------------------------------------------------------------
// rfd_front
// Front pipeline: center offsets, per axis corner distances, squares and the
// radicand in quarter units that feeds the square root chain.
// ----------------------------------------------------------------------------
module rfd_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [rfd_pkg::COORD_W-1:0]  pixel_x,
	input  logic [rfd_pkg::COORD_W-1:0]  pixel_y,
	input  rfd_pkg::geo_t                geo,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rfd_pkg::sqrt_t               out_data
);
	import rfd_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic ld1, ld2, ld3, ld4, ld5, ld6;

	logic [COORD_W-1:0] px_s1, py_s1;
	logic signed [18:0] dx_s2, dy_s2;
	logic signed [18:0] qx_s3, qy_s3;
	logic [17:0] ax_s4, ay_s4;
	logic signed [SIDE_W-1:0] m2_s4, m2_s5;
	logic [34:0] sqx_s5, sqy_s5;
	sqrt_t rad_s6;

	logic signed [18:0] dx_n, dy_n, adx, ady, qx_n, qy_n;
	logic signed [18:0] mx, mneg, mr;
	logic [35:0] sqx_n, sqy_n, sum_n;

	// stage loads, a stage moves when empty or when the next one moves
	assign ld6 = !valid_s6 || out_ready;
	assign ld5 = !valid_s5 || ld6;
	assign ld4 = !valid_s4 || ld5;
	assign ld3 = !valid_s3 || ld4;
	assign ld2 = !valid_s2 || ld3;
	assign ld1 = !valid_s1 || ld2;
	assign in_ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ld1) valid_s1 <= in_valid;
			if (ld2) valid_s2 <= valid_s1;
			if (ld3) valid_s3 <= valid_s2;
			if (ld4) valid_s4 <= valid_s3;
			if (ld5) valid_s5 <= valid_s4;
			if (ld6) valid_s6 <= valid_s5;
		end
	end

	// offset from the doubled center, half units
	always_comb begin
		dx_n = $signed({2'b00, px_s1, 1'b0}) - $signed({4'b0000, geo.l, 1'b0})
			- $signed({3'b000, geo.w});
		dy_n = $signed({2'b00, py_s1, 1'b0}) - $signed({4'b0000, geo.t, 1'b0})
			- $signed({3'b000, geo.h});
	end

	// distance past the straight edge of the corner box
	always_comb begin
		adx = dx_s2[18] ? -dx_s2 : dx_s2;
		ady = dy_s2[18] ? -dy_s2 : dy_s2;
		qx_n = adx + $signed({3'b000, geo.rs2}) - $signed({3'b000, geo.w});
		qy_n = ady + $signed({3'b000, geo.rs2}) - $signed({3'b000, geo.h});
	end

	// inside term and radius folded into one side value
	always_comb begin
		mx = (qx_s3 > qy_s3) ? qx_s3 : qy_s3;
		mneg = mx[18] ? mx : '0;
		mr = mneg - $signed({3'b000, geo.rs2});
	end

	// squares and radicand
	always_comb begin
		sqx_n = {18'd0, ax_s4} * {18'd0, ax_s4};
		sqy_n = {18'd0, ay_s4} * {18'd0, ay_s4};
		sum_n = {1'b0, sqx_s5} + {1'b0, sqy_s5};
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			px_s1 <= pixel_x;
			py_s1 <= pixel_y;
		end
		if (ld2) begin
			dx_s2 <= dx_n;
			dy_s2 <= dy_n;
		end
		if (ld3) begin
			qx_s3 <= qx_n;
			qy_s3 <= qy_n;
		end
		if (ld4) begin
			ax_s4 <= qx_s3[18] ? '0 : qx_s3[17:0];
			ay_s4 <= qy_s3[18] ? '0 : qy_s3[17:0];
			m2_s4 <= {mr[17:0], 1'b0};
		end
		if (ld5) begin
			sqx_s5 <= sqx_n[34:0];
			sqy_s5 <= sqy_n[34:0];
			m2_s5 <= m2_s4;
		end
		if (ld6) begin
			rad_s6.rem <= {sum_n, 2'b00};
			rad_s6.root <= '0;
			rad_s6.m2 <= m2_s5;
		end
	end

	assign out_valid = valid_s6;
	assign out_data = rad_s6;

endmodule

// File: hdl/rfd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rfd_sqrt_cell
// One cell of the square root chain: decides one root bit by a trial
// subtract and hands remainder, partial root and side value to the next cell.
// ----------------------------------------------------------------------------
module rfd_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rfd_pkg::sqrt_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output rfd_pkg::sqrt_t  out_data
);
	import rfd_pkg::*;

	localparam int TW = SQ_IN_W + 2;

	logic [TW-1:0] trial, rem_ext;
	logic take;
	logic valid_q;
	sqrt_t data_q, data_n;

	// (root + 2^BIT)^2 - root^2, root only holds bits above BIT
	always_comb begin
		trial = ({{(TW-SQ_ROOT_W){1'b0}}, in_data.root} << (BIT + 1))
			| ({{(TW-1){1'b0}}, 1'b1} << (2 * BIT));
		rem_ext = {2'b00, in_data.rem};
		take = rem_ext >= trial;
		data_n.rem = take ? (in_data.rem - trial[SQ_IN_W-1:0]) : in_data.rem;
		data_n.root = take ? (in_data.root | (SQ_ROOT_W'(1) << BIT)) : in_data.root;
		data_n.m2 = in_data.m2;
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			data_q <= data_n;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

// File: hdl/rounded_frame_distance_unit.sv
// ----------------------------------------------------------------------------
// rounded_frame_distance_unit
// Negated signed distance from a pixel to a rounded inner rectangle.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output does not stall and returns one
// distance per pixel through six front stages (offsets, corner distances,
// squares, radicand), a chain of 19 square root cells that settle one root
// bit each, a rounding stage and the output register. Every stage holds its
// item until the next one frees up, so a stalled output stops only the items
// behind it. Register writes reach the derived geometry through registers.
// ----------------------------------------------------------------------------
module rounded_frame_distance_unit (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data,
	// pixel stream
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [31:0]  s_axis_tdata,  // [15:0] pixel_x, [31:16] pixel_y
	// distance stream
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [23:0]  m_axis_tdata   // [17:0] frame_distance, [23:18] zero
);
	import rfd_pkg::*;

	localparam int NCELL = SQ_ROOT_W;

	geo_t geo;
	sqrt_t cell_d [0:NCELL];
	logic cell_v [0:NCELL];
	logic cell_rdy [0:NCELL];

	logic rnd_valid_s1, out_valid_s2;
	logic ld_rnd, ld_out;
	logic [SQ_ROOT_W:0] sq_s1;
	logic signed [SIDE_W-1:0] m2_s1;
	logic signed [DIST_W-1:0] dist_s2;
	logic [SQ_ROOT_W:0] sq_n;
	logic signed [20:0] nsum;

	// configuration and geometry
	rfd_geometry u_geometry (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.geo      (geo)
	);

	// front pipeline
	rfd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.pixel_x  (s_axis_tdata[15:0]),
		.pixel_y  (s_axis_tdata[31:16]),
		.geo      (geo),
		.out_valid(cell_v[0]),
		.out_ready(cell_rdy[0]),
		.out_data (cell_d[0])
	);

	// square root chain, most significant root bit first
	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		rfd_sqrt_cell #(
			.BIT(NCELL - 1 - c)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (cell_v[c]),
			.in_ready (cell_rdy[c]),
			.in_data  (cell_d[c]),
			.out_valid(cell_v[c+1]),
			.out_ready(cell_rdy[c+1]),
			.out_data (cell_d[c+1])
		);
	end

	// rounding and output stage loads
	assign ld_out = !out_valid_s2 || m_axis_tready;
	assign ld_rnd = !rnd_valid_s1 || ld_out;
	assign cell_rdy[NCELL] = ld_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_valid_s1 <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (ld_rnd) rnd_valid_s1 <= cell_v[NCELL];
			if (ld_out) out_valid_s2 <= rnd_valid_s1;
		end
	end

	// round the root to nearest, then -d rounded half up is floor((2 - v4) / 4)
	always_comb begin
		sq_n = {1'b0, cell_d[NCELL].root}
			+ (SQ_ROOT_W+1)'(cell_d[NCELL].rem > {{(SQ_IN_W-SQ_ROOT_W){1'b0}}, cell_d[NCELL].root});
		nsum = 21'sd2 - $signed({1'b0, sq_s1}) - $signed({{2{m2_s1[SIDE_W-1]}}, m2_s1});
	end

	// the value always fits the output range, so no clamp is needed
	always_ff @(posedge clk) begin
		if (ld_rnd) begin
			sq_s1 <= sq_n;
			m2_s1 <= cell_d[NCELL].m2;
		end
		if (ld_out) begin
			dist_s2 <= nsum[19:2];
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata = {6'd0, dist_s2};

	// an empty output stage lets every stage move, so the input is open
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output stage empty");

	// after the last cell the remainder stays within twice the root
	a_root_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[NCELL] |-> (cell_d[NCELL].rem
			<= {{(SQ_IN_W-SQ_ROOT_W-1){1'b0}}, cell_d[NCELL].root, 1'b0}))
		else $error("square root remainder out of range");

	// the side term carries minus twice the radius at least, never positive
	a_side_negative: assert property (@(posedge clk) disable iff (!arst_n)
		cell_v[NCELL] |-> cell_d[NCELL].m2[SIDE_W-1])
		else $error("side term lost its sign");

endmodule
